// ----- rtl/crce_pkg.sv -----
// Shared types and constants of the Catmull-Rom curve evaluator.
package crce_pkg;

	// field widths fixed by the item format
	localparam int POS_W      = 24;
	localparam int PIDX_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 9;

	// item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLOSED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 8'd1;

	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

endpackage

// ----- rtl/crce_if.sv -----
// Channel interfaces: point/evaluate input, curve result output, register write.
interface crce_in_if #(parameter int COORD_BITS = 24);
	logic                                valid;
	logic                                ready;
	logic                                mode;
	logic [crce_pkg::PIDX_W-1:0]         point_index;
	logic signed [COORD_BITS-1:0]        point_x;
	logic signed [COORD_BITS-1:0]        point_y;
	logic [crce_pkg::POS_W-1:0]          position;
	modport source (output valid, mode, point_index, point_x, point_y, position, input ready);
	modport sink   (input valid, mode, point_index, point_x, point_y, position, output ready);
endinterface

interface crce_out_if #(parameter int COORD_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] curve_x;
	logic signed [COORD_BITS-1:0] curve_y;
	logic                         empty_curve;
	modport source (output valid, curve_x, curve_y, empty_curve, input ready);
	modport sink   (input valid, curve_x, curve_y, empty_curve, output ready);
endinterface

interface crce_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [crce_pkg::CFG_IDX_W-1:0]   index;
	crce_pkg::cfg_data_t              data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/catmull_rom_curve_evaluator.sv -----
// Top level of the uniform Catmull-Rom curve evaluator.
//
//  channel    dir  beat contents
//  pt_in      in   mode, point_index, point_x, point_y, position
//  curve_out  out  curve_x, curve_y, empty_curve (one beat per evaluate)
//  cfg        in   index, data (register write, always ready)
//
// One beat per cycle in both directions while no untaken result stalls the output; an evaluate
// result passes index select and table read, coefficient/f^2, products/f^3, last product,
// then final sum and saturate. All stages advance together on one enable
// that drops only while the output register holds an untaken result.
// Reset clears valid bits and configuration registers; the point table is not cleared.
module catmull_rom_curve_evaluator #(
	parameter int MAX_POINTS      = 256,
	parameter int COORD_BITS      = 24,
	parameter int PARAM_FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	crce_cfg_if.sink     cfg,
	crce_in_if.sink      pt_in,
	crce_out_if.source   curve_out
);
	import crce_pkg::*;

	localparam int NB = $clog2(MAX_POINTS + 1);
	localparam int IB = $clog2(MAX_POINTS);
	localparam int F  = PARAM_FRAC_BITS;
	localparam int C  = COORD_BITS;
	localparam int PW = (POS_W > IB + F) ? POS_W : IB + F;
	localparam int AW = C + 4;
	localparam int SW = AW + F + 3;
	localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (C - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] LO = -HI - SW'(1);
	localparam logic [2*F-1:0] HALF = (2*F)'(1) << (F - 1);
	localparam logic signed [SW-1:0] RND = SW'(1) <<< F;

	// configuration registers
	logic          closed_q;
	cfg_data_t     count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			count_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CLOSED: closed_q <= cfg.data[0];
				REG_COUNT:  count_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline advance
	logic out_v_q;
	logic adv;
	logic acc;
	assign adv         = !out_v_q || curve_out.ready;
	assign pt_in.ready = adv;
	assign acc         = pt_in.valid && adv;

	// neighbour index selection
	logic [NB-1:0] n_c;
	logic [IB-1:0] last_c, i0_c, im_c, i1_c, i2_c;
	logic [IB:0]   i0p_c;
	logic [PW-1:0] pos_c, maxpos_c;
	logic [F-1:0]  f_c;
	logic          empty_c;

	always_comb begin
		n_c      = (count_q > MAX_POINTS) ? NB'(MAX_POINTS) : NB'(count_q);
		empty_c  = (n_c < NB'(2));
		last_c   = IB'(n_c - NB'(1));
		maxpos_c = PW'(last_c) << F;
		pos_c    = PW'(pt_in.position);
		if (pos_c > maxpos_c) pos_c = maxpos_c;
		i0_c  = IB'(pos_c >> F);
		f_c   = pos_c[F-1:0];
		im_c  = (i0_c != '0) ? i0_c - IB'(1) : (closed_q ? last_c : '0);
		i0p_c = {1'b0, i0_c} + (IB+1)'(1);
		i1_c  = (i0p_c < {1'b0, last_c}) ? i0p_c[IB-1:0] : last_c;
		i2_c  = (i1_c < last_c) ? i1_c + IB'(1) : (closed_q ? '0 : last_c);
	end

	// point table: four copies, one read port each
	logic          wr_en;
	logic [IB-1:0] wr_addr;
	logic          rd_en;
	logic [IB-1:0] rd_addr [4];
	logic [2*C-1:0] rd_s1 [4];

	assign wr_en   = acc && (pt_in.mode == MODE_WRITE) && (pt_in.point_index < MAX_POINTS);
	assign wr_addr = IB'(pt_in.point_index);
	assign rd_en   = acc && (pt_in.mode == MODE_EVAL);
	assign rd_addr[0] = im_c;
	assign rd_addr[1] = i0_c;
	assign rd_addr[2] = i1_c;
	assign rd_addr[3] = i2_c;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [2*C-1:0] mem [MAX_POINTS];
		always_ff @(posedge clk) begin
			if (wr_en) mem[wr_addr] <= {pt_in.point_x, pt_in.point_y};
			if (rd_en) rd_s1[b] <= mem[rd_addr[b]];
		end
	end

	// stage registers
	logic         v_s1, v_s2, v_s3, v_s4;
	logic         e_s1, e_s2, e_s3, e_s4;
	logic [F-1:0] f_s1, f_s2;
	logic [F-1:0] f2_s2, f3_s3;
	logic signed [AW-1:0] a0_s2 [2], a1_s2 [2], a2_s2 [2], a3_s2 [2], a3_s3 [2];
	logic signed [SW-1:0] t0_s3 [2], t1_s3 [2], t2_s3 [2];
	logic signed [SW-1:0] part_s4 [2], t3_s4 [2];

	// coefficients and f^2
	logic signed [AW-1:0] pm_c [2], p0_c [2], p1_c [2], p2_c [2];
	logic signed [AW-1:0] a0_c [2], a1_c [2], a2_c [2], a3_c [2];
	logic [2*F-1:0] ff_c, f3p_c;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			pm_c[k] = AW'($signed(rd_s1[0][(1-k)*C +: C]));
			p0_c[k] = AW'($signed(rd_s1[1][(1-k)*C +: C]));
			p1_c[k] = AW'($signed(rd_s1[2][(1-k)*C +: C]));
			p2_c[k] = AW'($signed(rd_s1[3][(1-k)*C +: C]));
			a0_c[k] = p0_c[k] <<< 1;
			a1_c[k] = p1_c[k] - pm_c[k];
			a2_c[k] = (pm_c[k] <<< 1) - ((p0_c[k] <<< 2) + p0_c[k]) + (p1_c[k] <<< 2) - p2_c[k];
			a3_c[k] = ((p0_c[k] - p1_c[k]) <<< 1) + (p0_c[k] - p1_c[k]) + p2_c[k] - pm_c[k];
		end
		ff_c  = f_s1 * f_s1 + HALF;
		f3p_c = f2_s2 * f_s2 + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1  <= empty_c;
			f_s1  <= f_c;
			e_s2  <= e_s1;
			f_s2  <= f_s1;
			f2_s2 <= ff_c[2*F-1:F];
			e_s3  <= e_s2;
			f3_s3 <= f3p_c[2*F-1:F];
			e_s4  <= e_s3;
			for (int k = 0; k < 2; k++) begin
				a0_s2[k]   <= a0_c[k];
				a1_s2[k]   <= a1_c[k];
				a2_s2[k]   <= a2_c[k];
				a3_s2[k]   <= a3_c[k];
				// first products
				t0_s3[k]   <= SW'(a0_s2[k]) <<< F;
				t1_s3[k]   <= a1_s2[k] * $signed({1'b0, f_s2});
				t2_s3[k]   <= a2_s2[k] * $signed({1'b0, f2_s2});
				a3_s3[k]   <= a3_s2[k];
				// cubic term and partial sum
				t3_s4[k]   <= a3_s3[k] * $signed({1'b0, f3_s3});
				part_s4[k] <= t0_s3[k] + t1_s3[k] + t2_s3[k];
			end
		end
	end

	// final sum, round half up, saturate
	logic signed [SW-1:0] sum_c [2], r_c [2];
	logic signed [C-1:0]  res_c [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			sum_c[k] = part_s4[k] + t3_s4[k] + RND;
			r_c[k]   = sum_c[k] >>> (F + 1);
			if (r_c[k] > HI)      res_c[k] = HI[C-1:0];
			else if (r_c[k] < LO) res_c[k] = LO[C-1:0];
			else                  res_c[k] = r_c[k][C-1:0];
		end
	end

	logic signed [C-1:0] x_q, y_q;
	logic                empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			empty_q <= e_s4;
			x_q     <= e_s4 ? '0 : res_c[0];
			y_q     <= e_s4 ? '0 : res_c[1];
		end
	end

	assign curve_out.valid       = out_v_q;
	assign curve_out.curve_x     = x_q;
	assign curve_out.curve_y     = y_q;
	assign curve_out.empty_curve = empty_q;

endmodule

// ----- rtl/crce_checker.sv -----
// Port-level checks of the curve evaluator and their binding.
module crce_port_checks #(
	parameter int COORD_BITS = 24
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] out_x,
	input logic [COORD_BITS-1:0] out_y,
	input logic                  out_empty,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);
	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
		&& $stable(out_empty))
		else $error("result beat changed under stall");

	// an empty curve reports the origin
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> out_x == '0 && out_y == '0)
		else $error("empty curve with nonzero point");

	// input is taken whenever the output register is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// register writes never stall
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write stalled");

	// no output ready without input ready when output is drained
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input stalled while result drains");
endmodule

bind catmull_rom_curve_evaluator crce_port_checks #(.COORD_BITS(COORD_BITS)) u_crce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pt_in.valid),
	.in_ready  (pt_in.ready),
	.out_valid (curve_out.valid),
	.out_ready (curve_out.ready),
	.out_x     (curve_out.curve_x),
	.out_y     (curve_out.curve_y),
	.out_empty (curve_out.empty_curve),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

// ----- sim/crce_checker.sv -----
// Scoreboard for the curve evaluator: tracks point writes and predicts each evaluate result.
`timescale 1ns / 1ps

module crce_checker (
	input  logic  clk,
	input  logic  arst_n,
	crce_cfg_if   cfg,
	crce_in_if    pt_in,
	crce_out_if   curve_out,
	output int    fail_count,
	output int    pending
);
	import crce_pkg::*;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic               empty;
	} curve_pt_t;

	curve_pt_t    curve_q[$];
	longint       x_tbl[256];
	longint       y_tbl[256];
	logic         wrap_ends;
	logic [8:0]   n_points;

	// cubic blend of one coordinate, rounded half up and saturated to 24 bits
	function automatic logic signed [23:0] blend_coord(longint pm, longint p0, longint p1,
			longint p2, longint f, longint f2, longint f3);
		longint a1, a2, a3, s, r;
		a1 = p1 - pm;
		a2 = 2 * pm - 5 * p0 + 4 * p1 - p2;
		a3 = -pm + 3 * p0 - 3 * p1 + p2;
		s = 2 * p0 * 65536 + a1 * f + a2 * f2 + a3 * f3;
		r = (s + 65536) >>> 17;
		if (r > 64'sd8388607)
			r = 64'sd8388607;
		if (r < -64'sd8388608)
			r = -64'sd8388608;
		return r[23:0];
	endfunction

	// neighbour selection and fraction powers for one curve parameter
	function automatic curve_pt_t predict_curve(logic [23:0] position);
		curve_pt_t c;
		longint n, p, maxp, i0, im, i1, i2, f, f2, f3;
		n = (n_points > 256) ? 256 : n_points;
		if (n < 2) begin
			c.x = '0;
			c.y = '0;
			c.empty = 1'b1;
			return c;
		end
		maxp = (n - 1) << 16;
		p = position;
		if (p > maxp)
			p = maxp;
		i0 = p >> 16;
		f = p & 65535;
		im = (i0 > 0) ? i0 - 1 : (wrap_ends ? n - 1 : 0);
		i1 = (i0 + 1 < n - 1) ? i0 + 1 : n - 1;
		i2 = (i1 < n - 1) ? i1 + 1 : (wrap_ends ? 0 : n - 1);
		f2 = (f * f + 32768) >> 16;
		f3 = (f2 * f + 32768) >> 16;
		c.x = blend_coord(x_tbl[im], x_tbl[i0], x_tbl[i1], x_tbl[i2], f, f2, f3);
		c.y = blend_coord(y_tbl[im], y_tbl[i0], y_tbl[i1], y_tbl[i2], f, f2, f3);
		c.empty = 1'b0;
		return c;
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// watch all three channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		curve_pt_t exp_c;
		if (!arst_n) begin
			wrap_ends = 1'b0;
			n_points = '0;
			curve_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_CLOSED)
					wrap_ends = cfg.data[0];
				else if (cfg.index == REG_COUNT)
					n_points = cfg.data;
			end
			if (pt_in.valid && pt_in.ready) begin
				if (pt_in.mode == MODE_WRITE) begin
					x_tbl[pt_in.point_index] = longint'(pt_in.point_x);
					y_tbl[pt_in.point_index] = longint'(pt_in.point_y);
				end else begin
					curve_q.push_back(predict_curve(pt_in.position));
				end
			end
			if (curve_out.valid && curve_out.ready) begin
				if (curve_q.size() == 0) begin
					$error("curve result beat with no evaluate outstanding");
					fail_count++;
				end else begin
					exp_c = curve_q.pop_front();
					if (curve_out.curve_x !== exp_c.x) begin
						$error("curve_x expected %0d got %0d", exp_c.x, curve_out.curve_x);
						fail_count++;
					end
					if (curve_out.curve_y !== exp_c.y) begin
						$error("curve_y expected %0d got %0d", exp_c.y, curve_out.curve_y);
						fail_count++;
					end
					if (curve_out.empty_curve !== exp_c.empty) begin
						$error("empty_curve expected %0b got %0b", exp_c.empty,
							curve_out.empty_curve);
						fail_count++;
					end
				end
			end
		end
		pending = curve_q.size();
	end

endmodule

// ----- sim/tb_catmull_rom_curve_evaluator.sv -----
// Stimulus and verdict for the Catmull-Rom curve evaluator.
`timescale 1ns / 1ps

module tb_catmull_rom_curve_evaluator;
	import crce_pkg::*;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;
	localparam int COORD_MAX = 8388607;
	localparam int COORD_MIN = -8388608;

	logic clk;
	logic arst_n;
	int   idle_mode;
	int   holdoff_req;
	int   fail_count;
	int   pending;
	int   phase_closed[8] = '{0, 1, 0, 1, 0, 1, 0, 1};
	int   phase_count[8]  = '{2, 3, 256, 256, 17, 511, 100, 1};

	crce_cfg_if  cfg ();
	crce_in_if   pt_in ();
	crce_out_if  curve_out ();

	catmull_rom_curve_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pt_in     (pt_in),
		.curve_out (curve_out)
	);

	crce_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pt_in      (pt_in),
		.curve_out  (curve_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

	// result receiver: random stalls per phase, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		curve_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req > 0) begin
				hold_left = holdoff_req;
				holdoff_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				curve_out.ready = 1'b0;
			end else if (idle_mode == IDLE_RECV)
				curve_out.ready = ($urandom_range(99) >= 88);
			else if (idle_mode == IDLE_BOTH)
				curve_out.ready = ($urandom_range(99) >= 38);
			else
				curve_out.ready = 1'b1;
		end
	end

	// register write; called only with nothing in flight
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		bit hit;
		pt_in.valid = 1'b0;
		wait (pending == 0);
		repeat (10) @(negedge clk);
		cfg.index = idx;
		cfg.data = value[CFG_DATA_W-1:0];
		cfg.valid = 1'b1;
		do begin
			#1 hit = cfg.ready;
			@(negedge clk);
		end while (!hit);
		cfg.valid = 1'b0;
	endtask

	// one input beat, with random sender gaps; returns at a falling edge
	task automatic send_beat(logic mode, int idx, int px, int py, int pos);
		bit hit;
		while ((idle_mode == IDLE_SEND && $urandom_range(99) < 88) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 38)) begin
			pt_in.valid = 1'b0;
			@(negedge clk);
		end
		pt_in.mode = mode;
		pt_in.point_index = idx[7:0];
		pt_in.point_x = px[23:0];
		pt_in.point_y = py[23:0];
		pt_in.position = pos[23:0];
		pt_in.valid = 1'b1;
		do begin
			#1 hit = pt_in.ready;
			@(negedge clk);
		end while (!hit);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(7))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return $urandom_range(2000) - 1000;
			default: return int'({{8{1'b0}}, 24'($urandom)}) - 8388608;
		endcase
	endfunction

	// random curve parameter, mostly inside the curve with fraction extremes mixed in
	function automatic int rand_pos(int n);
		int seg;
		if (n > 256)
			n = 256;
		if (n < 2 || $urandom_range(9) == 0)
			return $urandom_range(24'hFFFFFF);
		seg = $urandom_range(n - 1);
		case ($urandom_range(5))
			0: return seg << 16;
			1: return (seg << 16) | 16'hFFFF;
			default: return (seg << 16) | $urandom_range(16'hFFFF);
		endcase
	endfunction

	task automatic eval_at(int pos);
		send_beat(MODE_EVAL, $urandom_range(255), rand_coord(), rand_coord(), pos);
	endtask

	initial begin
		int n;
		idle_mode = IDLE_NONE;
		holdoff_req = 0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pt_in.valid = 1'b0;
		pt_in.mode = MODE_WRITE;
		pt_in.point_index = '0;
		pt_in.point_x = '0;
		pt_in.point_y = '0;
		pt_in.position = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole table so no evaluate reads an unwritten slot
		for (int i = 0; i < 256; i++)
			send_beat(MODE_WRITE, i, rand_coord(), rand_coord(), $urandom);
		pt_in.valid = 1'b0;

		// directed: empty curve, single point, oversize count, ends, saturation
		eval_at(0);
		write_reg(REG_COUNT, 1);
		eval_at(24'hFFFFFF);
		write_reg(REG_COUNT, 2);
		eval_at(0);
		eval_at(16'h8000);
		eval_at(24'hFFFFFF);
		write_reg(REG_COUNT, 511);
		eval_at(24'hFFFFFF);
		eval_at(255 << 16);
		eval_at((254 << 16) | 16'hFFFF);
		send_beat(MODE_WRITE, 0, COORD_MAX, COORD_MIN, 0);
		send_beat(MODE_WRITE, 1, COORD_MIN, COORD_MAX, 0);
		send_beat(MODE_WRITE, 2, COORD_MAX, COORD_MIN, 0);
		send_beat(MODE_WRITE, 3, COORD_MIN, COORD_MAX, 0);
		send_beat(MODE_WRITE, 255, COORD_MAX, COORD_MAX, 0);
		pt_in.valid = 1'b0;
		write_reg(REG_COUNT, 4);
		eval_at(16'h8000);
		eval_at((1 << 16) | 16'h8000);
		eval_at((2 << 16) | 16'hFFFF);
		eval_at(3 << 16);
		write_reg(REG_CLOSED, 1);
		eval_at(16'h4000);
		eval_at((2 << 16) | 16'h8000);
		eval_at(24'hFFFFFF);
		pt_in.valid = 1'b0;

		// random phases across settings and idling styles
		for (int ph = 0; ph < 8; ph++) begin
			n = phase_count[ph];
			if (ph == 6)
				n = $urandom_range(5, 255);
			write_reg(REG_CLOSED, phase_closed[ph]);
			write_reg(REG_COUNT, n);
			idle_mode = ph % 4;
			if (ph == 0)
				holdoff_req = 300;
			for (int k = 0; k < 53; k++) begin
				if ($urandom_range(9) < 3)
					send_beat(MODE_WRITE, $urandom_range(255), rand_coord(), rand_coord(),
						$urandom);
				else
					eval_at(rand_pos(n));
			end
			pt_in.valid = 1'b0;
		end

		idle_mode = IDLE_NONE;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
